// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rgdd_pkg.sv =====
// ---------------------------------------------------------------------------
// rgdd_pkg
// Item codes and field widths of the resource graph deadlock detector.
// ---------------------------------------------------------------------------
`default_nettype none

package rgdd_pkg;

  // Field widths of one input item
  localparam int FUNC_W = 2;
  localparam int PROC_W = 3;
  localparam int RES_W  = 3;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // Width used for node id arithmetic (holds resource id plus half offset)
  localparam int ID_W = 7;

  // Item kinds carried on in_tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_ASSIGN  = 2'd1,
    FUNC_CHECK   = 2'd2
  } func_t;

endpackage

`default_nettype wire

// ===== src/resource_graph_deadlock_detector_core.sv =====
// Edge items (request, assign): the row is read when the item is accepted and written back in
//   the next cycle; in_tready stays low during the write-back, so no item is taken meanwhile.
// Check items: each root tried, each node pushed (push, row load), each pop (pop, stack
//   reload) and each edge skipped takes its own steps; the search time is set by the single
//   read port of the edge row memory and of the search stack memory.
// Reset (rst_n low, synchronous) clears all row valid bits, so the graph starts empty.
// ---------------------------------------------------------------------------
// resource_graph_deadlock_detector_core
// Keeps a process/resource allocation graph in a row memory and runs an
// iterative depth-first cycle search over all nodes on a check item.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module resource_graph_deadlock_detector_core #(
  parameter int NODES = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [rgdd_pkg::IN_DATA_W-1:0]   in_tdata,  // [2:0] process_id, [5:3] resource_id
  input  wire logic [rgdd_pkg::FUNC_W-1:0]      in_tuser,  // [1:0] func
  // Result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [rgdd_pkg::OUT_DATA_W-1:0]       out_tdata  // [0] deadlock
);

  import rgdd_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DW = $clog2(NODES + 1);
  localparam logic [ID_W-1:0] HALF_ID  = ID_W'(NODES / 2);
  localparam logic [ID_W-1:0] NODES_ID = ID_W'(NODES);
  localparam logic [DW-1:0]   NODES_D  = DW'(NODES);

  typedef struct packed {
    logic [NW-1:0]    node;
    logic [NODES-1:0] rem;
  } stk_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_NEXT_ROOT,
    ST_LOAD,
    ST_SEARCH,
    ST_POP_WAIT,
    ST_FINISH
  } state_t;

  state_t           state_r;
  logic [NODES-1:0] seen_r;
  logic [NODES-1:0] onpath_r;
  logic [NODES-1:0] rem_r;
  logic [NW-1:0]    cur_v_r;
  logic [DW-1:0]    depth_r;
  logic [DW-1:0]    start_r;
  logic             flag_r;
  logic             out_tvalid_r;
  logic             out_flag_r;
  logic [NW-1:0]    ewr_from_r;
  logic [NW-1:0]    ewr_to_r;
  logic             ewr_ok_r;

  // Edge row memory with one valid bit per row
  logic [NODES-1:0] edge_mem [NODES];
  logic [NODES-1:0] edge_vld_r;
  logic [NODES-1:0] edge_rdata_r;
  logic             edge_rvld_r;
  logic [NW-1:0]    edge_raddr;
  logic             edge_we;
  logic [NODES-1:0] edge_row;

  // Search stack memory, entries below the cached top
  stk_entry_t       stk_mem [NODES];
  stk_entry_t       stk_rdata_r;
  stk_entry_t       stk_wdata;
  logic [NW-1:0]    stk_raddr;
  logic [NW-1:0]    stk_waddr;
  logic             stk_we;

  func_t            in_func;
  logic [ID_W-1:0]  proc_id;
  logic [ID_W-1:0]  res_id;
  logic             edge_ok;
  logic             in_xfer;
  logic             out_free;
  logic [NODES-1:0] low_bit;
  logic [NW-1:0]    low_idx;
  logic [DW-1:0]    depth_m1;
  logic [DW-1:0]    depth_m2;

  // Decode the incoming item
  always_comb begin
    in_func = func_t'(in_tuser);
    proc_id = ID_W'(in_tdata[PROC_W-1:0]);
    res_id  = ID_W'(in_tdata[PROC_W+RES_W-1:PROC_W]) + HALF_ID;
    edge_ok = (proc_id < HALF_ID) && (res_id < NODES_ID);
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Pick the lowest remaining successor of the top node
  always_comb begin
    low_bit = rem_r & (~rem_r + NODES'(1));
    low_idx = '0;
    for (int i = 0; i < NODES; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | NW'(i);
      end
    end
  end

  assign depth_m1 = depth_r - DW'(1);
  assign depth_m2 = depth_r - DW'(2);
  assign edge_row = edge_rvld_r ? edge_rdata_r : '0;

  // Memory address and write control
  always_comb begin
    edge_raddr = cur_v_r;
    edge_we    = 1'b0;
    stk_we     = 1'b0;
    stk_waddr  = depth_m1[NW-1:0];
    stk_raddr  = depth_m2[NW-1:0];
    stk_wdata.node = cur_v_r;
    stk_wdata.rem  = rem_r & ~low_bit;
    unique case (state_r)
      ST_IDLE: begin
        edge_raddr = (in_func == FUNC_ASSIGN) ? res_id[NW-1:0] : proc_id[NW-1:0];
      end
      ST_EDGE_WR: begin
        edge_we = ewr_ok_r;
      end
      ST_NEXT_ROOT: begin
        edge_raddr = start_r[NW-1:0];
      end
      ST_SEARCH: begin
        edge_raddr = low_idx;
        stk_we     = (rem_r != '0) && ((onpath_r & low_bit) == '0) &&
                     ((seen_r & low_bit) == '0);
      end
      default: begin
        edge_raddr = cur_v_r;
      end
    endcase
  end

  // Edge row memory: read every cycle, merge new edge on write
  always_ff @(posedge clk) begin
    edge_rdata_r <= edge_mem[edge_raddr];
    edge_rvld_r  <= edge_vld_r[edge_raddr];
    if (edge_we) begin
      edge_mem[ewr_from_r] <= edge_row | (NODES'(1) << ewr_to_r);
    end
  end

  // Row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_vld_r <= '0;
    end else if (edge_we) begin
      edge_vld_r[ewr_from_r] <= 1'b1;
    end
  end

  // Search stack memory
  always_ff @(posedge clk) begin
    stk_rdata_r <= stk_mem[stk_raddr];
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
  end

  // Control sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      depth_r      <= '0;
      seen_r       <= '0;
      onpath_r     <= '0;
      start_r      <= '0;
      flag_r       <= 1'b0;
      ewr_ok_r     <= 1'b0;
    end else begin
      // Drop the result once transferred; the finish state loads the next one
      if (out_tvalid_r && out_tready && (state_r != ST_FINISH)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            priority case (in_func)
              FUNC_REQUEST: begin
                ewr_from_r <= proc_id[NW-1:0];
                ewr_to_r   <= res_id[NW-1:0];
                ewr_ok_r   <= edge_ok;
                state_r    <= ST_EDGE_WR;
              end
              FUNC_ASSIGN: begin
                ewr_from_r <= res_id[NW-1:0];
                ewr_to_r   <= proc_id[NW-1:0];
                ewr_ok_r   <= edge_ok;
                state_r    <= ST_EDGE_WR;
              end
              FUNC_CHECK: begin
                seen_r   <= '0;
                onpath_r <= '0;
                depth_r  <= '0;
                start_r  <= '0;
                state_r  <= ST_NEXT_ROOT;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_EDGE_WR: begin
          state_r <= ST_IDLE;
        end
        ST_NEXT_ROOT: begin
          // Try the next unseen node as a search root
          if (start_r == NODES_D) begin
            flag_r  <= 1'b0;
            state_r <= ST_FINISH;
          end else if (seen_r[start_r[NW-1:0]]) begin
            start_r <= start_r + DW'(1);
          end else begin
            cur_v_r  <= start_r[NW-1:0];
            seen_r   <= seen_r | (NODES'(1) << start_r[NW-1:0]);
            onpath_r <= onpath_r | (NODES'(1) << start_r[NW-1:0]);
            depth_r  <= DW'(1);
            start_r  <= start_r + DW'(1);
            state_r  <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          rem_r   <= edge_row;
          state_r <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (rem_r == '0) begin
            // Pop the finished node
            onpath_r <= onpath_r & ~(NODES'(1) << cur_v_r);
            depth_r  <= depth_m1;
            state_r  <= (depth_r == DW'(1)) ? ST_NEXT_ROOT : ST_POP_WAIT;
          end else if ((onpath_r & low_bit) != '0) begin
            // Back edge onto the current path
            flag_r  <= 1'b1;
            state_r <= ST_FINISH;
          end else if ((seen_r & low_bit) != '0) begin
            rem_r <= rem_r & ~low_bit;
          end else begin
            // Push the successor, its row arrives next cycle
            cur_v_r  <= low_idx;
            seen_r   <= seen_r | low_bit;
            onpath_r <= onpath_r | low_bit;
            depth_r  <= depth_r + DW'(1);
            state_r  <= ST_LOAD;
          end
        end
        ST_POP_WAIT: begin
          cur_v_r <= stk_rdata_r.node;
          rem_r   <= stk_rdata_r.rem;
          state_r <= ST_SEARCH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_flag_r   <= flag_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'(out_flag_r);

  // Checks
  `ASSERT_ALWAYS(a_depth_bound, depth_r <= NODES_D, "search stack deeper than node count")
  `ASSERT_ALWAYS(a_path_in_seen, (onpath_r & ~seen_r) == '0, "path node not marked seen")
  `ASSERT_IMPLY(a_path_count, state_r == ST_SEARCH, $countones(onpath_r) == int'(depth_r),
    "path mask does not match stack depth")
  `ASSERT_NEXT(a_check_clear, in_xfer && (in_func == FUNC_CHECK),
    (seen_r == '0) && (depth_r == '0), "check did not clear search state")

endmodule

`default_nettype wire
